// ===== src/amna_pkg.sv =====
// Package for the airspeed / Mach needle angle core: shared types, codes and
// fixed-point constants. No dependencies.
package amna_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLEW_STEP     = 2'd0;
  localparam logic [1:0] CFG_SLEW_ZONE     = 2'd1;
  localparam logic [1:0] CFG_ZERO_CUTOFF   = 2'd2;
  localparam logic [1:0] CFG_MACH_DEADBAND = 2'd3;

  typedef struct packed {
    logic [10:0] slew_step;
    logic [13:0] slew_zone;
    logic [13:0] zero_cutoff;
    logic [12:0] mach_deadband;
  } cfg_t;

  // Datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV5, OP_SCAP, OP_HLO, OP_HHI, OP_HACC, OP_TARGET,
    OP_NEEDLE, OP_FRAC, OP_IDX, OP_LO, OP_HI, OP_IMUL, OP_LN, OP_KLO, OP_KHI,
    OP_TMACH, OP_ANG, OP_HOLD, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV5, ST_SCAP, ST_HLO, ST_HHI, ST_HACC, ST_TARGET, ST_NEEDLE,
    ST_FRAC, ST_IDX, ST_LO, ST_HI, ST_IMUL, ST_LN, ST_KLO, ST_KHI, ST_TMACH,
    ST_ANG, ST_HOLD, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] coef_idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // Polynomial coefficients in Q24, index = power of s
  localparam logic signed [47:0] POLY_COEF [6] = '{
    48'sd4509935043, -48'sd6621418267, 48'sd2071586349,
    -48'sd10956219, -48'sd1433748, 48'sd22665
  };

  localparam logic [15:0] AS_FULL      = 16'd59814;
  localparam logic [15:0] AS_MAX       = 16'd59815;
  localparam logic [31:0] RECIP5_Q24   = 32'd3355444;
  localparam logic signed [33:0] LN2_Q30   = 34'sd744261118;
  localparam logic signed [33:0] LN125_Q30 = 34'sd239598565;
  localparam logic [31:0] MACH_K_Q8    = 32'd11711429;
  localparam logic signed [39:0] MACH_C_Q8 = 40'sd20977112;
  localparam logic signed [17:0] MACH_LOW  = 18'sd63525;
  localparam logic [15:0] MACH_RAW_LOW = 16'd6144;

endpackage

// ===== src/airspeed_mach_needle_angles_core.sv =====
// Top level of the airspeed / Mach needle angle core: config registers,
// sequencer and datapath. Depends on amna_pkg, amna_ctrl, amna_dp.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   in_      | in_valid / in_stall | in_airspeed_raw (s32), in_mach_raw (u16)
//   out_     | out_valid/out_stall | out_airspeed_angle (u16), out_mach_angle (s18)
//   cfg_     | cfg_valid/cfg_ready | cfg_index (2b), cfg_data (14b)
//
// Each request is walked from acceptance to a loaded result through one shared
// 32x32 multiplier: the five Horner steps (two partial products plus accumulate
// each), then the ln interpolation and the Mach scaling. in_stall is high for
// the whole sequence, so a new request is taken only once the sequencer is back
// in idle. The output register frees the input side: a new request is taken
// while a result still waits; the sequencer only holds at its last step when the
// previous result has not been taken.
// Reset is synchronous; it clears the needle, the held Mach angle and the
// config registers to their defaults. The ln table is constant logic.
module airspeed_mach_needle_angles_core import amna_pkg::*; #(
  parameter int LnEntries = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_airspeed_raw,
  input  logic [15:0]        in_mach_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_airspeed_angle,
  output logic signed [17:0] out_mach_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data
);

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slew_step     <= 11'd128;
      cfg_r.slew_zone     <= 14'd1280;
      cfg_r.zero_cutoff   <= 14'd768;
      cfg_r.mach_deadband <= 13'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLEW_STEP:     cfg_r.slew_step     <= cfg_data[10:0];
        CFG_SLEW_ZONE:     cfg_r.slew_zone     <= cfg_data;
        CFG_ZERO_CUTOFF:   cfg_r.zero_cutoff   <= cfg_data;
        CFG_MACH_DEADBAND: cfg_r.mach_deadband <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  amna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  amna_dp #(.LnEntries(LnEntries)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg                (cfg_r),
    .in_airspeed_raw    (in_airspeed_raw),
    .in_mach_raw        (in_mach_raw),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_airspeed_angle (out_airspeed_angle),
    .out_mach_angle     (out_mach_angle)
  );

endmodule

// ===== src/amna_ctrl.sv =====
// Sequencer for the airspeed / Mach needle angle core.
// Depends on amna_pkg; drives the datapath by command, reads its status.
module amna_ctrl import amna_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 3'd4;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIV5;
      ST_DIV5:   state_nxt = ST_SCAP;
      ST_SCAP: begin
        state_nxt = ST_HLO;
        k_nxt     = 3'd4;
      end
      ST_HLO:    state_nxt = ST_HHI;
      ST_HHI:    state_nxt = ST_HACC;
      ST_HACC: begin
        if (k_r == 3'd0) begin
          state_nxt = ST_TARGET;
        end else begin
          k_nxt     = k_r - 3'd1;
          state_nxt = ST_HLO;
        end
      end
      ST_TARGET: state_nxt = ST_NEEDLE;
      ST_NEEDLE: state_nxt = ST_FRAC;
      ST_FRAC:   state_nxt = ST_IDX;
      ST_IDX:    state_nxt = ST_LO;
      ST_LO:     state_nxt = ST_HI;
      ST_HI:     state_nxt = ST_IMUL;
      ST_IMUL:   state_nxt = ST_LN;
      ST_LN:     state_nxt = ST_KLO;
      ST_KLO:    state_nxt = ST_KHI;
      ST_KHI:    state_nxt = ST_TMACH;
      ST_TMACH:  state_nxt = ST_ANG;
      ST_ANG:    state_nxt = ST_HOLD;
      ST_HOLD:   state_nxt = ST_EMIT;
      ST_EMIT:   if (!status.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.coef_idx = k_r;
    in_stall     = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_DIV5:   cmd.op = OP_DIV5;
      ST_SCAP:   cmd.op = OP_SCAP;
      ST_HLO:    cmd.op = OP_HLO;
      ST_HHI:    cmd.op = OP_HHI;
      ST_HACC:   cmd.op = OP_HACC;
      ST_TARGET: cmd.op = OP_TARGET;
      ST_NEEDLE: cmd.op = OP_NEEDLE;
      ST_FRAC:   cmd.op = OP_FRAC;
      ST_IDX:    cmd.op = OP_IDX;
      ST_LO:     cmd.op = OP_LO;
      ST_HI:     cmd.op = OP_HI;
      ST_IMUL:   cmd.op = OP_IMUL;
      ST_LN:     cmd.op = OP_LN;
      ST_KLO:    cmd.op = OP_KLO;
      ST_KHI:    cmd.op = OP_KHI;
      ST_TMACH:  cmd.op = OP_TMACH;
      ST_ANG:    cmd.op = OP_ANG;
      ST_HOLD:   cmd.op = OP_HOLD;
      ST_EMIT:   cmd.op = status.out_busy ? OP_NONE : OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== src/amna_dp.sv =====
// Datapath for the airspeed / Mach needle angle core: shared 32x32 multiplier,
// ln table, needle and Mach state, output register. Depends on amna_pkg.
module amna_dp import amna_pkg::*; #(
  parameter int LnEntries = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  cfg_t               cfg,
  input  logic signed [31:0] in_airspeed_raw,
  input  logic [15:0]        in_mach_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_airspeed_angle,
  output logic signed [17:0] out_mach_angle
);

  localparam int IW = $clog2(LnEntries + 1);

  function automatic logic [31:0] ln_series(input logic [63:0] z);
    logic [63:0] z2;
    logic [63:0] pw;
    logic [63:0] sum;
    z2  = (z * z) >> 30;
    pw  = z;
    sum = 64'd0;
    for (int k = 1; k <= 39; k += 2) begin
      sum = sum + pw / 64'(k);
      pw  = (pw * z2) >> 30;
    end
    return 32'(sum << 1);
  endfunction

  // ln(1 + i/LnEntries) in Q30
  logic [31:0] ln_tab [LnEntries + 1];
  for (genvar gi = 0; gi <= LnEntries; gi++) begin : g_ln
    localparam logic [63:0] Z = (64'(gi) << 30) / 64'(2 * LnEntries + gi);
    assign ln_tab[gi] = ln_series(Z);
  end

  logic signed [31:0] raw_r;
  logic [15:0]        mraw_r;
  logic [17:0]        s_r;
  logic signed [47:0] acc_r;
  logic [63:0]        prod_r, plo_r;
  logic [15:0]        target_r, needle_r;
  logic [3:0]         p_r;
  logic [IW-1:0]      idx_r;
  logic [15:0]        r_r;
  logic [31:0]        lo_r, hi_r;
  logic signed [33:0] ln_r;
  logic signed [35:0] t_r;
  logic signed [17:0] ang_r, held_r;
  logic               out_valid_r;
  logic [15:0]        out_as_r;
  logic signed [17:0] out_mach_r;

  logic [31:0]        mul_a, mul_b;
  logic [47:0]        acc_mag;
  logic [31:0]        ln_mag;
  logic [3:0]         p_enc;
  logic [15:0]        frac;

  assign acc_mag = acc_r[47] ? 48'(-acc_r) : 48'(acc_r);
  assign ln_mag  = ln_r[33] ? 32'(-ln_r) : 32'(ln_r);

  always_comb begin
    p_enc = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mraw_r[i]) p_enc = 4'(i);
    end
  end
  assign frac = 16'({mraw_r, 16'h0000} >> p_enc);

  // Multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      OP_DIV5: begin
        mul_a = {12'd0, raw_r[15:0], 4'd0};
        mul_b = RECIP5_Q24;
      end
      OP_HLO: begin
        mul_a = {8'd0, acc_mag[23:0]};
        mul_b = {14'd0, s_r};
      end
      OP_HHI: begin
        mul_a = {8'd0, acc_mag[47:24]};
        mul_b = {14'd0, s_r};
      end
      OP_FRAC: begin
        mul_a = {16'd0, frac};
        mul_b = 32'(LnEntries);
      end
      OP_IMUL: begin
        mul_a = hi_r - lo_r;
        mul_b = {16'd0, r_r};
      end
      OP_KLO: begin
        mul_a = MACH_K_Q8;
        mul_b = {16'd0, ln_mag[15:0]};
      end
      OP_KHI: begin
        mul_a = MACH_K_Q8;
        mul_b = {16'd0, ln_mag[31:16]};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Combinational step results
  logic [65:0]        h_sum;
  logic [47:0]        h_q;
  logic signed [47:0] h_qs;
  logic signed [24:0] a_s;
  logic [15:0]        target_nxt;
  logic signed [16:0] n_diff;
  logic [16:0]        n_adiff;
  logic [15:0]        needle_nxt;
  logic [32:0]        lnf;
  logic signed [33:0] pterm;
  logic [63:0]        t_sum;
  logic [33:0]        t_q;
  logic signed [39:0] a8, a8s;
  logic signed [17:0] ang_nxt;
  logic signed [18:0] m_diff;
  logic [18:0]        m_adiff;

  always_comb begin
    h_sum = {2'd0, plo_r} + ({2'd0, prod_r} << 24);
    h_q   = h_sum[59:12];
    h_qs  = acc_r[47] ? -$signed(h_q) : $signed(h_q);

    a_s = acc_r[47] ? -$signed({1'b0, acc_mag[47:24]}) : $signed({1'b0, acc_mag[47:24]});
    if (raw_r > 32'sd51200) begin
      target_nxt = AS_FULL;
    end else if (raw_r <= 32'sd0) begin
      target_nxt = 16'd0;
    end else if (a_s < $signed({11'd0, cfg.zero_cutoff})) begin
      target_nxt = 16'd0;
    end else if (a_s > $signed({9'd0, AS_MAX})) begin
      target_nxt = AS_MAX;
    end else begin
      target_nxt = a_s[15:0];
    end

    n_diff  = $signed({1'b0, target_r}) - $signed({1'b0, needle_r});
    n_adiff = n_diff[16] ? 17'(-n_diff) : 17'(n_diff);
    if (target_r < {2'd0, cfg.slew_zone} && n_adiff > {6'd0, cfg.slew_step}) begin
      if (target_r > needle_r) needle_nxt = needle_r + {5'd0, cfg.slew_step};
      else                     needle_nxt = needle_r - {5'd0, cfg.slew_step};
    end else begin
      needle_nxt = target_r;
    end

    lnf = {1'b0, lo_r} + {1'b0, prod_r[47:16]};
    case (p_r)
      4'd12:   pterm = -(LN2_Q30 <<< 1);
      4'd13:   pterm = -LN2_Q30;
      4'd15:   pterm = LN2_Q30;
      default: pterm = 34'sd0;
    endcase

    t_sum = plo_r + (prod_r << 16);
    t_q   = t_sum[63:30];

    a8  = 40'sd16777216 - MACH_C_Q8 - 40'(t_r) + $signed({16'd0, needle_r, 8'd0});
    a8s = (a8 + 40'sd128) >>> 8;
    if (mraw_r <= MACH_RAW_LOW)       ang_nxt = MACH_LOW;
    else if (a8s < -40'sd131072)      ang_nxt = -18'sd131072;
    else if (a8s > 40'sd131071)       ang_nxt = 18'sd131071;
    else                              ang_nxt = a8s[17:0];

    m_diff  = $signed({ang_r[17], ang_r}) - $signed({held_r[17], held_r});
    m_adiff = m_diff[18] ? 19'(-m_diff) : 19'(m_diff);
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    case (cmd.op)
      OP_LOAD: begin
        raw_r  <= in_airspeed_raw;
        mraw_r <= in_mach_raw;
      end
      OP_SCAP: begin
        s_r   <= prod_r[41:24];
        acc_r <= POLY_COEF[5];
      end
      OP_HHI:    plo_r <= prod_r;
      OP_HACC:   acc_r <= h_qs + POLY_COEF[cmd.coef_idx];
      OP_TARGET: target_r <= target_nxt;
      OP_FRAC:   p_r <= p_enc;
      OP_IDX: begin
        idx_r <= prod_r[16 +: IW];
        r_r   <= prod_r[15:0];
      end
      OP_LO:     lo_r <= ln_tab[idx_r];
      OP_HI:     hi_r <= ln_tab[idx_r + IW'(1)];
      OP_LN:     ln_r <= pterm + $signed({1'b0, lnf}) - LN125_Q30;
      OP_KHI:    plo_r <= prod_r;
      OP_TMACH:  t_r <= ln_r[33] ? -$signed({2'd0, t_q}) : $signed({2'd0, t_q});
      OP_ANG:    ang_r <= ang_nxt;
      OP_EMIT: begin
        out_as_r   <= needle_r;
        out_mach_r <= held_r;
      end
      default: ;
    endcase
  end

  // Persistent gauge state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r    <= 16'd0;
      held_r      <= 18'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_NEEDLE) needle_r <= needle_nxt;
      if (cmd.op == OP_HOLD && m_adiff >= {6'd0, cfg.mach_deadband}) held_r <= ang_r;
      if (cmd.op == OP_EMIT)   out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  assign status.out_busy    = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_airspeed_angle = out_as_r;
  assign out_mach_angle     = out_mach_r;

endmodule

// ===== src/amna_checker.sv =====
// Port-level checks for the airspeed / Mach needle angle core, bound to the
// top level. Depends only on the top level's ports.
module amna_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_airspeed_angle,
  input logic signed [17:0] out_mach_angle
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_airspeed_angle)
      && $stable(out_mach_angle))
    else $error("stalled result changed");

  // An accepted request keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // Needle angle never exceeds full scale
  a_needle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_airspeed_angle <= 16'd59815)
    else $error("airspeed angle out of range");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind airspeed_mach_needle_angles_core amna_checker u_amna_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_airspeed_angle (out_airspeed_angle),
  .out_mach_angle     (out_mach_angle)
);

// ===== tb/sv/airspeed_mach_needle_angles_core_tb.sv =====
// Testbench for airspeed_mach_needle_angles_core: it drives random and
// directed samples, predicts both needle angles and checks every result.
// Depends on amna_pkg and the core RTL.
`timescale 1ns / 100ps

module airspeed_mach_needle_angles_core_tb;
  import amna_pkg::*;

  // Predicts the needle angles and holds the expected results in order.
  class needle_scoreboard;
    typedef struct {
      logic [15:0]        airspeed_angle;
      logic signed [17:0] mach_angle;
    } angles_t;

    localparam int LN_N = 256;
    localparam longint COEF [6] = '{64'sd4509935043, -64'sd6621418267,
      64'sd2071586349, -64'sd10956219, -64'sd1433748, 64'sd22665};

    longint unsigned ln_frac_tab [LN_N+1];
    logic [10:0] step_q;
    logic [13:0] zone_q;
    logic [13:0] cutoff_q;
    logic [12:0] deadband_q;
    longint needle_q;
    longint held_q;
    angles_t expected_angles [$];
    int errors;

    function new();
      longint unsigned z, z2, pw, sum;
      for (int i = 0; i <= LN_N; i++) begin
        z = (longint'(i) << 30) / (2 * LN_N + i);
        z2 = (z * z) >> 30;
        pw = z;
        sum = 0;
        for (int k = 1; k <= 39; k += 2) begin
          sum += pw / k;
          pw = (pw * z2) >> 30;
        end
        ln_frac_tab[i] = (2 * sum) & 64'hFFFF_FFFF;
      end
      step_q = 128;
      zone_q = 1280;
      cutoff_q = 768;
      deadband_q = 256;
      needle_q = 0;
      held_q = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [13:0] data);
      case (idx)
        CFG_SLEW_STEP:     step_q = data[10:0];
        CFG_SLEW_ZONE:     zone_q = data;
        CFG_ZERO_CUTOFF:   cutoff_q = data;
        CFG_MACH_DEADBAND: deadband_q = data[12:0];
        default: ;
      endcase
    endfunction

    function longint speed_target(longint raw);
      longint s, acc, a;
      if (raw > 51200) return 59814;
      if (raw <= 0) return 0;
      s = raw * 16 / 5;
      acc = COEF[5];
      for (int k = 4; k >= 0; k--) acc = acc * s / 4096 + COEF[k];
      a = acc / 16777216;
      if (a < longint'(cutoff_q)) return 0;
      if (a > 59815) a = 59815;
      return a;
    endfunction

    function longint ln_mach_q30(logic [15:0] raw);
      int p;
      longint unsigned frac, scaled, i, r, lo, hi;
      p = 15;
      while (p > 0 && raw[p] == 1'b0) p--;
      frac = ((longint'(raw) << (16 - p)) - 65536) & 64'hFFFF;
      scaled = frac * LN_N;
      i = scaled >> 16;
      r = scaled & 64'hFFFF;
      lo = ln_frac_tab[i];
      hi = ln_frac_tab[i+1];
      return longint'(p - 14) * 744261118 + longint'(lo + (((hi - lo) * r) >> 16))
             - 239598565;
    endfunction

    function void note_request(logic signed [31:0] speed, logic [15:0] mach);
      longint target, diff, t, a8, ang, md;
      angles_t e;
      target = speed_target(longint'(speed));
      diff = target - needle_q;
      if (diff < 0) diff = -diff;
      if (target < longint'(zone_q) && diff > longint'(step_q)) begin
        needle_q = (target > needle_q) ? needle_q + step_q : needle_q - step_q;
      end else begin
        needle_q = target;
      end
      if (needle_q < 0) needle_q = 0;
      if (needle_q > 65535) needle_q = 65535;
      if (mach > 6144) begin
        t = 64'sd11711429 * ln_mach_q30(mach) / 64'sd1073741824;
        a8 = 65536 * 256 - 20977112 - t + needle_q * 256 + 128;
        ang = (a8 >= 0) ? a8 / 256 : -((-a8 + 255) / 256);
      end else begin
        ang = 63525;
      end
      if (ang < -131072) ang = -131072;
      if (ang > 131071) ang = 131071;
      md = ang - held_q;
      if (md < 0) md = -md;
      if (md >= longint'(deadband_q)) held_q = ang;
      e.airspeed_angle = needle_q[15:0];
      e.mach_angle = held_q[17:0];
      expected_angles.push_back(e);
    endfunction

    function void check_result(logic [15:0] speed_ang, logic [17:0] mach_ang);
      angles_t e;
      if (expected_angles.size() == 0) begin
        $error("result with nothing expected: airspeed_angle %0d mach_angle %0d",
               speed_ang, $signed(mach_ang));
        errors++;
        return;
      end
      e = expected_angles.pop_front();
      if (speed_ang !== e.airspeed_angle) begin
        $error("airspeed_angle: expected %0d, got %0d", e.airspeed_angle, speed_ang);
        errors++;
      end
      if (mach_ang !== e.mach_angle) begin
        $error("mach_angle: expected %0d, got %0d", e.mach_angle, $signed(mach_ang));
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_airspeed_raw = '0;
  logic [15:0]        in_mach_raw = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_airspeed_angle;
  logic signed [17:0] out_mach_angle;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_SLEW_STEP;
  logic [13:0]        cfg_data = '0;

  needle_scoreboard angles_sb = new();
  int  accepted_cnt = 0;
  int  burst_left = 1;
  logic hold_off = 1'b0;
  logic [1:0] stall_mode = 2'd0;
  int  mode_cnt = 0;

  airspeed_mach_needle_angles_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_airspeed_raw(in_airspeed_raw), .in_mach_raw(in_mach_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_airspeed_angle(out_airspeed_angle), .out_mach_angle(out_mach_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note each accepted request and check each accepted result at the edge,
  // before any driver update of that edge lands.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      angles_sb.note_request(in_airspeed_raw, in_mach_raw);
      accepted_cnt++;
    end
    if (rst_n && out_valid && !out_stall)
      angles_sb.check_result(out_airspeed_angle, out_mach_angle);
    if (cfg_valid && cfg_ready)
      angles_sb.write_reg(cfg_index, cfg_data);
  end

  // Receiver: switch at random among no stall, light stall and heavy stall;
  // a hold-off forces stall for a long stretch.
  always @(posedge clk) begin
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 64 == 63) stall_mode <= 2'($urandom_range(0, 2));
    out_stall <= hold_off
               | (stall_mode == 2'd1 && $urandom_range(0, 3) == 0)
               | (stall_mode == 2'd2 && $urandom_range(0, 3) != 0);
  end

  // Hold off the receiver long enough to back the block up into its input.
  initial begin
    wait (accepted_cnt >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Bounded run time; the slowest correct run is far below this.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one request and wait for it to be taken; close a burst with a gap.
  task automatic send_request(logic signed [31:0] speed, logic [15:0] mach);
    int gap;
    in_valid <= 1'b1;
    in_airspeed_raw <= speed;
    in_mach_raw <= mach;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one register write and wait for it to be taken; the caller drops
  // cfg_valid after the last write of a sequence.
  task automatic write_cfg(logic [1:0] idx, logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain all results, then let the sequencer settle before touching config.
  task automatic drain;
    in_valid <= 1'b0;
    while (angles_sb.expected_angles.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(int step, int zone, int cutoff, int deadband);
    write_cfg(CFG_SLEW_STEP, 14'(step));
    write_cfg(CFG_SLEW_ZONE, 14'(zone));
    write_cfg(CFG_ZERO_CUTOFF, 14'(cutoff));
    write_cfg(CFG_MACH_DEADBAND, 14'(deadband));
    cfg_valid <= 1'b0;
  endtask

  // Mostly in the polynomial range, some past full scale, negative or wild.
  function automatic logic signed [31:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'($urandom_range(51190, 51210));
      2: return -32'sd1 * 32'($urandom_range(0, 2000));
      3: return 32'($urandom_range(1, 4000));
      default: return 32'($urandom_range(1, 51200));
    endcase
  endfunction

  function automatic logic [15:0] pick_mach();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(6100, 6200));
      default: return 16'($urandom_range(6145, 65535));
    endcase
  endfunction

  task automatic random_requests(int n);
    repeat (n) send_request(pick_speed(), pick_mach());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, zone edges, mach threshold and powers of two.
    send_request(32'sh8000_0000, 16'd0);
    send_request(-32'sd1, 16'd6144);
    send_request(32'sd0, 16'd6145);
    send_request(32'sd1, 16'd65535);
    send_request(32'sd51200, 16'd32768);
    send_request(32'sd51201, 16'd16384);
    send_request(32'sh7FFF_FFFF, 16'd8192);
    send_request(32'sd1280, 16'd1);
    send_request(32'sd3000, 16'd6500);
    send_request(32'sd6000, 16'd20480);
    send_request(32'sd12800, 16'd40000);
    send_request(32'sd25600, 16'd65535);
    send_request(32'sd640, 16'd6145);
    send_request(32'sd100, 16'd12288);
    send_request(-32'sd51200, 16'd24576);
    send_request(32'sd51200, 16'd6144);

    // Defaults, long hold-off lands here.
    random_requests(170);
    drain();

    // Slew below 8192 at the finest step, no cutoff, no deadband.
    set_regs(1, 8192, 0, 0);
    send_request(32'sd51201, 16'd65535);
    send_request(32'sd1, 16'd6145);
    random_requests(170);
    drain();

    // Never slew, cutoff 8192, deadband 4096.
    set_regs(1024, 0, 8192, 4096);
    random_requests(170);
    drain();

    // Out-of-range register values: zero step, all-ones fields.
    set_regs(0, 16383, 16383, 8191);
    random_requests(40);
    drain();
    set_regs(2047, 3000, 100, 50);
    random_requests(60);
    drain();

    // Random settings.
    set_regs($urandom_range(1, 1024), $urandom_range(0, 8192),
             $urandom_range(0, 8192), $urandom_range(0, 4096));
    random_requests(100);
    drain();

    if (angles_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
